// ===== hw/rtl/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the task dispatch scoreboard.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int unsigned TaskIds    = 32;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned Resources  = 32;
  localparam int unsigned IdW        = $clog2(TaskIds);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned RdCntW     = 6;
  localparam logic [RdCntW-1:0] ReaderMax = '1;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_START  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RUN  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NONE     = 3'd1,
    ST_FULL     = 3'd2,
    ST_STATE    = 3'd3,
    ST_CONFLICT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic [31:0] read_mask;
    logic [31:0] write_mask;
    logic [31:0] depend_mask;
    logic [1:0]  command;
    logic [4:0]  task_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       popped_valid;
    logic [4:0] popped_id;
  } rsp_t;

  // control from the sequencer to the queue cells
  typedef struct packed {
    logic           push;       // write id at tail
    logic           shift;      // compact from hole position
    logic [QCntW-1:0] hole;     // slot being removed
    logic [QCntW-1:0] count;    // current fill
    logic [IdW-1:0] push_id;
  } qctl_t;

endpackage

// ===== hw/rtl/tds_if.sv =====
// ----------------------------------------------------------------------------
// tds_if
// Valid/ready channels carrying one beat of cmd_t or rsp_t payload.
// ----------------------------------------------------------------------------
interface tds_cmd_if;
  import tds_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tds_rsp_if;
  import tds_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tds_qcell.sv =====
// ----------------------------------------------------------------------------
// tds_qcell
// One slot of the ordered wait queue; takes its right neighbor's id on shift.
// ----------------------------------------------------------------------------
module tds_qcell (
  input  logic                  clk_i,
  input  tds_pkg::qctl_t        ctl_i,
  input  logic [tds_pkg::QCntW-1:0] pos_i,
  input  logic [tds_pkg::IdW-1:0] next_id_i,
  output logic [tds_pkg::IdW-1:0] id_o
);
  import tds_pkg::*;

  logic [IdW-1:0] id_q, id_d;

  always_comb begin
    id_d = id_q;
    if (ctl_i.push && pos_i == ctl_i.count) id_d = ctl_i.push_id;
    if (ctl_i.shift && pos_i >= ctl_i.hole) id_d = next_id_i;
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;
endmodule

// ===== hw/rtl/task_dispatch_scoreboard_unit.sv =====
// ----------------------------------------------------------------------------
// task_dispatch_scoreboard_unit
// Reader/writer resource scoreboard with an ordered wait queue.
// ----------------------------------------------------------------------------
// Usage: one command beat in on cmd (push, pop, start, finish), one response
// beat out on rsp for every command. The block handles one command at a time.
// Push, start and finish go from EXEC straight to OUT, raising response valid.
// Pop walks the queue cells one slot per cycle, oldest first, checking the
// eligibility of each entry, then compacts the row of cells in one shift
// if an entry was eligible; the states run EXEC, SCAN, SHIFT (only on a
// find) and OUT. The queue is a chain of cells, each holding one id and
// taking its neighbor's id on shift.
// A new command is accepted in the cycle after the previous response has
// been taken, so commands never overlap.
// While the receiver stalls the response is held steady in its register.
// Reset clears phases, write flags, reader counts and queue fill; mask
// stores are not cleared and are only read for tasks that were pushed.
// ----------------------------------------------------------------------------
module task_dispatch_scoreboard_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tds_cmd_if.sink   cmd,
  tds_rsp_if.source rsp
);
  import tds_pkg::*;

  fsm_e state_q, state_d;
  cmd_t cmd_q;
  rsp_t rsp_q, rsp_d;

  logic [1:0]  phase_q [TaskIds];
  logic [Resources-1:0] reads_q [TaskIds];
  logic [Resources-1:0] writes_q[TaskIds];
  logic [TaskIds-1:0]   deps_q  [TaskIds];
  logic [RdCntW-1:0] rdcnt_q [Resources];
  logic [Resources-1:0] wbusy_q;
  logic [QCntW-1:0] qcnt_q;
  logic [QCntW-1:0] scan_q;

  logic [IdW-1:0] qid [QueueDepth+1];
  qctl_t qctl;

  assign qid[QueueDepth] = '0;
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    tds_qcell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (qctl),
      .pos_i     (QCntW'(g)),
      .next_id_i (qid[g+1]),
      .id_o      (qid[g])
    );
  end

  // eligibility of a selected task
  logic [Resources-1:0] rd_present;
  logic [TaskIds-1:0]   done_vec;
  always_comb begin
    for (int r = 0; r < Resources; r++) rd_present[r] = rdcnt_q[r] != '0;
    for (int t = 0; t < TaskIds; t++) done_vec[t] = phase_q[t] == PH_DONE;
  end

  logic [IdW-1:0] scan_id, chk_id;
  logic free_chk, deps_chk, elig;
  assign scan_id  = qid[scan_q[$clog2(QueueDepth)-1:0]];
  assign chk_id   = (cmd_q.command[1:0] == CMD_POP) ? scan_id : cmd_q.task_id;
  assign free_chk = ((writes_q[chk_id] & (wbusy_q | rd_present)) == '0) &&
                    ((reads_q[chk_id] & wbusy_q) == '0);
  assign deps_chk = (deps_q[chk_id] & ~done_vec) == '0;
  assign elig     = free_chk && deps_chk;

  logic [1:0] cur_ph;
  assign cur_ph = phase_q[cmd_q.task_id];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:  if (cmd.valid) state_d = FSM_EXEC;
      FSM_EXEC:  if (cmd_q.command[1:0] == CMD_POP) state_d = FSM_SCAN;
                 else state_d = FSM_OUT;
      FSM_SCAN:  if (scan_q >= qcnt_q) state_d = FSM_OUT;
                 else if (elig) state_d = FSM_SHIFT;
      FSM_SHIFT: state_d = FSM_OUT;
      FSM_OUT:   if (rsp.ready) state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    qctl = '0;
    qctl.count = qcnt_q;
    qctl.hole = scan_q;
    qctl.push_id = cmd_q.task_id;
    rsp_d = rsp_q;
    if (state_q == FSM_EXEC) begin
      rsp_d = '{status: ST_OK, popped_valid: 1'b0, popped_id: '0};
      case (cmd_q.command[1:0])
        CMD_PUSH: begin
          if (cur_ph != PH_NONE) rsp_d.status = ST_STATE;
          else if (qcnt_q >= QCntW'(QueueDepth)) rsp_d.status = ST_FULL;
          else qctl.push = 1'b1;
        end
        CMD_POP: rsp_d.status = ST_NONE;
        CMD_START: begin
          if (cur_ph != PH_WAIT) rsp_d.status = ST_STATE;
          else if (!free_chk) rsp_d.status = ST_CONFLICT;
        end
        default: if (cur_ph != PH_RUN) rsp_d.status = ST_STATE;
      endcase
    end
    if (state_q == FSM_SCAN && scan_q < qcnt_q && elig) begin
      rsp_d = '{status: ST_OK, popped_valid: 1'b1, popped_id: scan_id};
    end
    if (state_q == FSM_SHIFT) qctl.shift = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      qcnt_q  <= '0;
      wbusy_q <= '0;
      scan_q  <= '0;
      for (int t = 0; t < TaskIds; t++) phase_q[t] <= PH_NONE;
      for (int r = 0; r < Resources; r++) rdcnt_q[r] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FSM_IDLE) scan_q <= '0;
      if (state_q == FSM_SCAN && state_d == FSM_SCAN) scan_q <= scan_q + 1'b1;
      if (qctl.push) begin
        qcnt_q <= qcnt_q + 1'b1;
        phase_q[cmd_q.task_id] <= PH_WAIT;
      end
      if (qctl.shift) qcnt_q <= qcnt_q - 1'b1;
      if (state_q == FSM_EXEC && rsp_d.status == ST_OK) begin
        if (cmd_q.command[1:0] == CMD_START) begin
          phase_q[cmd_q.task_id] <= PH_RUN;
          wbusy_q <= wbusy_q | writes_q[cmd_q.task_id];
          for (int r = 0; r < Resources; r++)
            if (reads_q[cmd_q.task_id][r] && rdcnt_q[r] != ReaderMax)
              rdcnt_q[r] <= rdcnt_q[r] + 1'b1;
        end else if (cmd_q.command[1:0] == CMD_FINISH) begin
          phase_q[cmd_q.task_id] <= PH_DONE;
          wbusy_q <= wbusy_q & ~writes_q[cmd_q.task_id];
          for (int r = 0; r < Resources; r++)
            if (reads_q[cmd_q.task_id][r] && rdcnt_q[r] != '0)
              rdcnt_q[r] <= rdcnt_q[r] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == FSM_IDLE && cmd.valid) cmd_q <= cmd.data;
    if (qctl.push) begin
      reads_q[cmd_q.task_id]  <= cmd_q.read_mask[Resources-1:0];
      writes_q[cmd_q.task_id] <= cmd_q.write_mask[Resources-1:0];
      deps_q[cmd_q.task_id]   <= cmd_q.depend_mask[TaskIds-1:0];
    end
  end

  assign cmd.ready = state_q == FSM_IDLE;
  assign rsp.valid = state_q == FSM_OUT;
  assign rsp.data  = rsp_q;
endmodule

// ===== hw/rtl/tds_checker.sv =====
// ----------------------------------------------------------------------------
// tds_checker
// Port-level checks of the scoreboard: no accept while a response is pending,
// popped id and status consistency, and response hold under stall.
module tds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cmd_valid_i,
  input logic cmd_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input tds_pkg::rsp_t rsp_data_i
);
  import tds_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_ready_i && rsp_valid_i)) else $error("accept while response pending");

  a_pid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_data_i.popped_valid |-> rsp_data_i.popped_id == '0)
    else $error("popped id not zero");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.popped_valid |-> rsp_data_i.status == ST_OK)
    else $error("popped with error status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response dropped");
endmodule

bind task_dispatch_scoreboard_unit tds_checker u_tds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd.valid),
  .cmd_ready_i (cmd.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_data_i  (rsp.data)
);
